// ===== src/etmb_pkg.sv =====
// Shared types and constants for the Euler ZYX scale/translate matrix builder.
// Used by etmb_cordic, etmb_rot, etmb_lane and euler_trs_matrix_builder; no dependencies.
package etmb_pkg;

	localparam int ANGLE_W      = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int PHASE_W      = 32;
	localparam int TRIG_W       = 32;
	localparam int CORD_W       = 34;
	localparam int Z_W          = 32;
	localparam int CORDIC_STEPS = 28;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
	localparam int ROT_LAT      = 3;
	localparam int FRONT_LAT    = CORDIC_LAT + ROT_LAT;

	localparam int SCALE_W = 16;
	localparam int TRANS_W = 32;
	localparam int ELEM_W  = 32;
	localparam int ROT_W   = TRIG_W + 1;
	localparam int PROD_W  = SCALE_W + ROT_W;
	localparam int NUM_W   = ROT_W - 6;
	localparam int DEN_W   = SCALE_W;
	localparam int DIV_STEPS = NUM_W;
	localparam int LANE_LAT  = DIV_STEPS + 3;

	localparam int FIFO_DEPTH = 2;

	localparam logic [1:0] LAST_COL = 2'd3;

	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	typedef enum logic [1:0] {
		K_MODEL,
		K_DIV,
		K_PASS
	} kind_t;

	typedef logic [2:0][2:0][ROT_W-1:0] rotm_t;

	typedef struct packed {
		logic                       normal;
		logic signed [SCALE_W-1:0]  sx;
		logic signed [SCALE_W-1:0]  sy;
		logic signed [SCALE_W-1:0]  sz;
		logic signed [TRANS_W-1:0]  tx;
		logic signed [TRANS_W-1:0]  ty;
		logic signed [TRANS_W-1:0]  tz;
	} side_t;

	typedef struct packed {
		logic [1:0] col;
		logic       zflag;
		logic       last;
	} tag_t;

	typedef struct packed {
		tag_t                      tag;
		logic signed [ELEM_W-1:0]  e0;
		logic signed [ELEM_W-1:0]  e1;
		logic signed [ELEM_W-1:0]  e2;
	} result_t;

endpackage

// ===== src/etmb_cordic.sv =====
// Pipelined rotation-mode CORDIC: one binary angle in, cosine and sine out in Q2.30.
// Depends on etmb_pkg.
module etmb_cordic (
	input  logic                               clk,
	input  logic                               adv,
	input  logic [etmb_pkg::ANGLE_W-1:0]       angle,
	output logic signed [etmb_pkg::TRIG_W-1:0] cos_v,
	output logic signed [etmb_pkg::TRIG_W-1:0] sin_v
);
	import etmb_pkg::*;

	localparam logic signed [CORD_W-1:0] ONE = CORD_W'(1) << 30;

	logic [PHASE_W-1:0]       phase;
	logic signed [CORD_W-1:0] x_q [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] y_q [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]    z_q [CORDIC_STEPS+1];
	logic [1:0]               quad_q [CORDIC_STEPS+1];
	logic signed [CORD_W-1:0] xc, yc;
	logic signed [TRIG_W-1:0] c_d, s_d;
	logic signed [TRIG_W-1:0] cos_q, sin_q;

	assign phase = {angle[ANGLE_BITS-1:0], {(PHASE_W-ANGLE_BITS){1'b0}}};

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q[0]    <= CORDIC_GAIN;
			y_q[0]    <= '0;
			z_q[0]    <= $signed({2'b00, phase[PHASE_W-3:0]});
			quad_q[0] <= phase[PHASE_W-1:PHASE_W-2];
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_q[k][Z_W-1]) begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - $signed(ATAN_TAB[k]);
				end else begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + $signed(ATAN_TAB[k]);
				end
				quad_q[k+1] <= quad_q[k];
			end
		end
	end

	always_comb begin
		xc = x_q[CORDIC_STEPS];
		yc = y_q[CORDIC_STEPS];
		if (xc > ONE) xc = ONE;
		else if (xc < -ONE) xc = -ONE;
		if (yc > ONE) yc = ONE;
		else if (yc < -ONE) yc = -ONE;
		case (quad_q[CORDIC_STEPS])
			2'd0: begin
				c_d = TRIG_W'(xc);
				s_d = TRIG_W'(yc);
			end
			2'd1: begin
				c_d = TRIG_W'(-yc);
				s_d = TRIG_W'(xc);
			end
			2'd2: begin
				c_d = TRIG_W'(-xc);
				s_d = TRIG_W'(-yc);
			end
			default: begin
				c_d = TRIG_W'(yc);
				s_d = TRIG_W'(-xc);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cos_q <= c_d;
			sin_q <= s_d;
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

// ===== src/etmb_rot.sv =====
// Three-stage product network that forms R = Rz * Ry * Rx from sines and cosines.
// Depends on etmb_pkg.
module etmb_rot (
	input  logic                               clk,
	input  logic                               adv,
	input  logic signed [etmb_pkg::TRIG_W-1:0] c1,
	input  logic signed [etmb_pkg::TRIG_W-1:0] s1,
	input  logic signed [etmb_pkg::TRIG_W-1:0] c2,
	input  logic signed [etmb_pkg::TRIG_W-1:0] s2,
	input  logic signed [etmb_pkg::TRIG_W-1:0] c3,
	input  logic signed [etmb_pkg::TRIG_W-1:0] s3,
	output etmb_pkg::rotm_t                    rot
);
	import etmb_pkg::*;

	localparam logic signed [2*TRIG_W-1:0] HALF30 = (2*TRIG_W)'(1) << 29;

	function automatic logic signed [TRIG_W-1:0] mul30(
		input logic signed [TRIG_W-1:0] a,
		input logic signed [TRIG_W-1:0] b
	);
		logic signed [2*TRIG_W-1:0] p;
		p = a * b;
		p = p + HALF30;
		return TRIG_W'(p >>> 30);
	endfunction

	logic signed [TRIG_W-1:0] c1c2_s1, c2s1_s1, c1s2_s1, c3s1_s1, c1c3_s1;
	logic signed [TRIG_W-1:0] s1s2_s1, c2s3_s1, s1s3_s1, c1s3_s1, c2c3_s1;
	logic signed [TRIG_W-1:0] s2_s1, s3_s1;

	logic signed [TRIG_W-1:0] c1c2_s2, c2s1_s2, c3s1_s2, c1c3_s2;
	logic signed [TRIG_W-1:0] c2s3_s2, s1s3_s2, c1s3_s2, c2c3_s2, s2_s2;
	logic signed [TRIG_W-1:0] t10_s2, t11_s2, t20_s2, t21_s2;

	rotm_t rot_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			c1c2_s1 <= mul30(c1, c2);
			c2s1_s1 <= mul30(c2, s1);
			c1s2_s1 <= mul30(c1, s2);
			c3s1_s1 <= mul30(c3, s1);
			c1c3_s1 <= mul30(c1, c3);
			s1s2_s1 <= mul30(s1, s2);
			c2s3_s1 <= mul30(c2, s3);
			s1s3_s1 <= mul30(s1, s3);
			c1s3_s1 <= mul30(c1, s3);
			c2c3_s1 <= mul30(c2, c3);
			s2_s1   <= s2;
			s3_s1   <= s3;

			t10_s2  <= mul30(c1s2_s1, s3_s1);
			t11_s2  <= mul30(s1s2_s1, s3_s1);
			t20_s2  <= mul30(c1c3_s1, s2_s1);
			t21_s2  <= mul30(c3s1_s1, s2_s1);
			c1c2_s2 <= c1c2_s1;
			c2s1_s2 <= c2s1_s1;
			c3s1_s2 <= c3s1_s1;
			c1c3_s2 <= c1c3_s1;
			c2s3_s2 <= c2s3_s1;
			s1s3_s2 <= s1s3_s1;
			c1s3_s2 <= c1s3_s1;
			c2c3_s2 <= c2c3_s1;
			s2_s2   <= s2_s1;

			rot_s3[0][0] <= ROT_W'(c1c2_s2);
			rot_s3[0][1] <= ROT_W'(c2s1_s2);
			rot_s3[0][2] <= -ROT_W'(s2_s2);
			rot_s3[1][0] <= ROT_W'(t10_s2) - ROT_W'(c3s1_s2);
			rot_s3[1][1] <= ROT_W'(c1c3_s2) + ROT_W'(t11_s2);
			rot_s3[1][2] <= ROT_W'(c2s3_s2);
			rot_s3[2][0] <= ROT_W'(s1s3_s2) + ROT_W'(t20_s2);
			rot_s3[2][1] <= ROT_W'(t21_s2) - ROT_W'(c1s3_s2);
			rot_s3[2][2] <= ROT_W'(c2c3_s2);
		end
	end

	assign rot = rot_s3;

endmodule

// ===== src/etmb_lane.sv =====
// One row lane of the column stage: scale multiply for model columns and a
// pipelined restoring divider for normal columns. Depends on etmb_pkg.
module etmb_lane (
	input  logic                                clk,
	input  logic                                adv,
	input  etmb_pkg::kind_t                     kind,
	input  logic signed [etmb_pkg::ROT_W-1:0]   entry,
	input  logic signed [etmb_pkg::SCALE_W-1:0] scale,
	input  logic signed [etmb_pkg::ELEM_W-1:0]  pass,
	output logic signed [etmb_pkg::ELEM_W-1:0]  elem
);
	import etmb_pkg::*;

	localparam logic signed [PROD_W-1:0] HALF22 = PROD_W'(1) << 21;

	logic [ROT_W-1:0]   emag;
	logic [DEN_W-1:0]   smag;
	logic [ROT_W-1:0]   nsum;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;
	logic [NUM_W-1:0]         num_s1;
	logic [DEN_W-1:0]         den_s1;
	logic                     neg_s1;
	kind_t                    kind_s1;
	logic signed [ELEM_W-1:0] pass_s1;

	logic [DEN_W-1:0]         rem_q  [DIV_STEPS+1];
	logic [NUM_W-1:0]         num_q  [DIV_STEPS+1];
	logic [NUM_W-1:0]         quo_q  [DIV_STEPS+1];
	logic [DEN_W-1:0]         den_q  [DIV_STEPS+1];
	logic                     neg_q  [DIV_STEPS+1];
	kind_t                    kind_q [DIV_STEPS+1];
	logic signed [ELEM_W-1:0] val_q  [DIV_STEPS+1];

	logic signed [ELEM_W-1:0] qs;
	logic signed [ELEM_W-1:0] elem_q;

	assign emag = entry[ROT_W-1] ? ROT_W'(-entry) : ROT_W'(entry);
	assign smag = scale[SCALE_W-1] ? DEN_W'(-scale) : DEN_W'(scale);
	assign nsum = emag + ROT_W'({smag, 5'b0});

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= scale * entry;
			num_s1  <= nsum[ROT_W-1:6];
			den_s1  <= smag;
			neg_s1  <= entry[ROT_W-1] ^ scale[SCALE_W-1];
			kind_s1 <= kind;
			pass_s1 <= pass;
		end
	end

	assign rnd = prod_s1 + HALF22;

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0]  <= '0;
			num_q[0]  <= num_s1;
			quo_q[0]  <= '0;
			den_q[0]  <= den_s1;
			neg_q[0]  <= neg_s1;
			kind_q[0] <= kind_s1;
			val_q[0]  <= (kind_s1 == K_MODEL) ? ELEM_W'(rnd >>> 22) : pass_s1;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic           take;
		assign trial = {rem_q[k], num_q[k][NUM_W-1]};
		assign take  = trial >= {1'b0, den_q[k]};
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_q[k+1]  <= take ? DEN_W'(trial - {1'b0, den_q[k]}) : DEN_W'(trial);
				num_q[k+1]  <= num_q[k] << 1;
				quo_q[k+1]  <= {quo_q[k][NUM_W-2:0], take};
				den_q[k+1]  <= den_q[k];
				neg_q[k+1]  <= neg_q[k];
				kind_q[k+1] <= kind_q[k];
				val_q[k+1]  <= val_q[k];
			end
		end
	end

	assign qs = ELEM_W'(quo_q[DIV_STEPS]);

	always_ff @(posedge clk) begin
		if (adv) begin
			case (kind_q[DIV_STEPS])
				K_DIV:   elem_q <= neg_q[DIV_STEPS] ? -qs : qs;
				default: elem_q <= val_q[DIV_STEPS];
			endcase
		end
	end

	assign elem = elem_q;

endmodule

// ===== src/euler_trs_matrix_builder.sv =====
// Euler ZYX rotation, scale and translation matrix builder, four columns per request.
// Columns 0..3 follow in order; results are taken one per cycle unless result_stall.
// Requests are taken only while the input counter is idle; the column sequencer feeds
// one column per cycle into the three row lanes while the result queue is not full.
// Reset clears all valid bits, the column sequencer and the two-entry result queue.
// Depends on etmb_pkg, etmb_cordic, etmb_rot and etmb_lane.
module euler_trs_matrix_builder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic                                 cmd,
	input  logic [etmb_pkg::ANGLE_W-1:0]         angle_x,
	input  logic [etmb_pkg::ANGLE_W-1:0]         angle_y,
	input  logic [etmb_pkg::ANGLE_W-1:0]         angle_z,
	input  logic signed [etmb_pkg::SCALE_W-1:0]  scale_x,
	input  logic signed [etmb_pkg::SCALE_W-1:0]  scale_y,
	input  logic signed [etmb_pkg::SCALE_W-1:0]  scale_z,
	input  logic signed [etmb_pkg::TRANS_W-1:0]  trans_x,
	input  logic signed [etmb_pkg::TRANS_W-1:0]  trans_y,
	input  logic signed [etmb_pkg::TRANS_W-1:0]  trans_z,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [1:0]                           column,
	output logic signed [etmb_pkg::ELEM_W-1:0]   elem_row0,
	output logic signed [etmb_pkg::ELEM_W-1:0]   elem_row1,
	output logic signed [etmb_pkg::ELEM_W-1:0]   elem_row2,
	output logic                                 zero_scale,
	output logic                                 last
);
	import etmb_pkg::*;

	logic       adv, accept, pop, push;
	logic [1:0] icnt_q;
	logic [1:0] fcnt_q;
	logic       wr_q, rd_q;
	result_t    fifo_q [FIFO_DEPTH];
	result_t    res_d;

	logic  fv_q   [FRONT_LAT];
	side_t side_q [FRONT_LAT];
	side_t side_d;

	logic signed [TRIG_W-1:0] cx, sx, cy, sy, cz, sz;
	rotm_t rot;

	logic       hold_vld_q;
	logic [1:0] col_q;
	rotm_t      hold_rot_q;
	side_t      hold_side_q;

	logic [1:0]                csel;
	logic signed [SCALE_W-1:0] scl;
	logic                      zs;
	kind_t                     kind;
	logic signed [ELEM_W-1:0]  pass [3];
	logic signed [ELEM_W-1:0]  elem [3];
	logic signed [TRANS_W-1:0] tr [3];
	tag_t                      tag_d;

	logic tv_q  [LANE_LAT];
	tag_t tag_q [LANE_LAT];

	assign adv        = fcnt_q != 2'(FIFO_DEPTH);
	assign item_stall = !(adv && icnt_q == 2'd0);
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icnt_q <= '0;
		end else if (adv) begin
			if (accept || icnt_q != 2'd0) icnt_q <= icnt_q + 2'd1;
		end
	end

	assign side_d = '{normal: cmd, sx: scale_x, sy: scale_y, sz: scale_z,
		tx: trans_x, ty: trans_y, tz: trans_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRONT_LAT; i++) fv_q[i] <= 1'b0;
		end else if (adv) begin
			fv_q[0] <= accept;
			for (int i = 1; i < FRONT_LAT; i++) fv_q[i] <= fv_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_d;
			for (int i = 1; i < FRONT_LAT; i++) side_q[i] <= side_q[i-1];
		end
	end

	etmb_cordic u_cordic_x (.clk(clk), .adv(adv), .angle(angle_x), .cos_v(cx), .sin_v(sx));
	etmb_cordic u_cordic_y (.clk(clk), .adv(adv), .angle(angle_y), .cos_v(cy), .sin_v(sy));
	etmb_cordic u_cordic_z (.clk(clk), .adv(adv), .angle(angle_z), .cos_v(cz), .sin_v(sz));

	etmb_rot u_rot (
		.clk(clk), .adv(adv),
		.c1(cz), .s1(sz), .c2(cy), .s2(sy), .c3(cx), .s3(sx),
		.rot(rot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			col_q      <= '0;
		end else if (adv) begin
			if (fv_q[FRONT_LAT-1]) begin
				hold_vld_q <= 1'b1;
				col_q      <= '0;
			end else if (hold_vld_q) begin
				if (col_q == LAST_COL) hold_vld_q <= 1'b0;
				else col_q <= col_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fv_q[FRONT_LAT-1]) begin
			hold_rot_q  <= rot;
			hold_side_q <= side_q[FRONT_LAT-1];
		end
	end

	assign tr[0] = hold_side_q.tx;
	assign tr[1] = hold_side_q.ty;
	assign tr[2] = hold_side_q.tz;

	always_comb begin
		csel = (col_q == LAST_COL) ? 2'd0 : col_q;
		case (csel)
			2'd0:    scl = hold_side_q.sx;
			2'd1:    scl = hold_side_q.sy;
			default: scl = hold_side_q.sz;
		endcase
		zs = hold_side_q.normal && col_q != LAST_COL && scl == '0;
		if (col_q == LAST_COL || zs) kind = K_PASS;
		else if (hold_side_q.normal) kind = K_DIV;
		else kind = K_MODEL;
		for (int r = 0; r < 3; r++) begin
			pass[r] = (col_q == LAST_COL && !hold_side_q.normal) ? tr[r] : '0;
		end
		tag_d = '{col: col_q, zflag: zs, last: col_q == LAST_COL};
	end

	for (genvar r = 0; r < 3; r++) begin : g_lane
		etmb_lane u_lane (
			.clk(clk), .adv(adv), .kind(kind),
			.entry($signed(hold_rot_q[csel][r])), .scale(scl),
			.pass(pass[r]), .elem(elem[r])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) tv_q[i] <= 1'b0;
		end else if (adv) begin
			tv_q[0] <= hold_vld_q;
			for (int i = 1; i < LANE_LAT; i++) tv_q[i] <= tv_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q[0] <= tag_d;
			for (int i = 1; i < LANE_LAT; i++) tag_q[i] <= tag_q[i-1];
		end
	end

	assign push  = adv && tv_q[LANE_LAT-1];
	assign pop   = result_valid && !result_stall;
	assign res_d = '{tag: tag_q[LANE_LAT-1], e0: elem[0], e1: elem[1], e2: elem[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fcnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   fcnt_q <= fcnt_q + 2'd1;
				2'b01:   fcnt_q <= fcnt_q - 2'd1;
				default: fcnt_q <= fcnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= res_d;
	end

	assign result_valid = fcnt_q != 2'd0;
	assign column       = fifo_q[rd_q].tag.col;
	assign zero_scale   = fifo_q[rd_q].tag.zflag;
	assign last         = fifo_q[rd_q].tag.last;
	assign elem_row0    = fifo_q[rd_q].e0;
	assign elem_row1    = fifo_q[rd_q].e1;
	assign elem_row2    = fifo_q[rd_q].e2;

endmodule
